// ----- design/least_squares_blend_coefficients_defines.svh -----
// assertion macros shared by the checker
`ifndef LEAST_SQUARES_BLEND_COEFFICIENTS_DEFINES_SVH
`define LEAST_SQUARES_BLEND_COEFFICIENTS_DEFINES_SVH

// condition implies property in the same cycle
`define LSBC_ASSERT_IMP(lbl, cond, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// condition implies property in the next cycle
`define LSBC_ASSERT_NXT(lbl, cond, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ----- design/lsbc_pkg.sv -----
package lsbc_pkg;

    localparam int SAMPLE_WIDTH = 16;
    localparam int ACC_W        = 48;
    localparam int HALF_W       = ACC_W / 2;
    localparam int WIDE_W       = 98;
    localparam int FRAC_W       = 16;
    localparam int DIVN_W       = WIDE_W + FRAC_W;
    localparam int DCNT_W       = $clog2(DIVN_W + 1);
    localparam int Q_W          = 33;
    localparam int MUL_STEPS    = 24;
    localparam int QDEPTH       = 4;
    localparam int QPTR_W       = $clog2(QDEPTH);

    localparam logic [16:0] ONE_Q16  = 17'h10000;
    localparam logic [31:0] HALF_Q16 = 32'h0000_8000;

    localparam logic REG_BLEND_MODE   = 1'b0;
    localparam logic REG_WEIGHT_FLOOR = 1'b1;

    typedef enum logic [1:0] {
        MODE_SINGLE,
        MODE_PAIR,
        MODE_HALF,
        MODE_RAND
    } lsbc_mode_t;

    typedef enum logic [2:0] {
        ST_ACC,
        ST_PREP,
        ST_MUL,
        ST_DGO_M,
        ST_DW_M,
        ST_DGO_F,
        ST_DW_F,
        ST_FIN
    } lsbc_state_t;

    typedef enum logic [1:0] {
        TGT_DET,
        TGT_NM,
        TGT_NF
    } lsbc_tgt_t;

    typedef struct packed {
        logic signed [15:0] target;
        logic signed [15:0] first;
        logic signed [15:0] second;
        logic        [15:0] rand_fraction;
        logic               last;
    } lsbc_sample_t;

    typedef struct packed {
        logic                     start;
        logic signed [WIDE_W-1:0] num;
        logic signed [WIDE_W-1:0] den;
    } lsbc_div_req_t;

    typedef struct packed {
        logic               done;
        logic               dz;
        logic signed [31:0] quot;
    } lsbc_div_rsp_t;

    function automatic logic signed [15:0] sext_sample(input logic [15:0] v);
        logic signed [SAMPLE_WIDTH-1:0] s;
        s = signed'(v[SAMPLE_WIDTH-1:0]);
        return 16'(s);
    endfunction

endpackage

// ----- design/lsbc_in_if.sv -----
interface lsbc_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] target;
    logic signed [15:0] first_model_out;
    logic signed [15:0] second_model_out;
    logic        [15:0] rand_fraction;
    logic               last_sample;

    modport source (output valid, target, first_model_out, second_model_out,
                    rand_fraction, last_sample, input ready);
    modport sink (input valid, target, first_model_out, second_model_out,
                  rand_fraction, last_sample, output ready);
endinterface

// ----- design/lsbc_out_if.sv -----
interface lsbc_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] weight_first;
    logic signed [31:0] weight_second;
    logic               weights_valid;

    modport source (output valid, weight_first, weight_second, weights_valid,
                    input ready);
    modport sink (input valid, weight_first, weight_second, weights_valid,
                  output ready);
endinterface

// ----- design/lsbc_front.sv -----
module lsbc_front (
    input  logic                  clk,
    input  logic                  rst_n,
    lsbc_in_if.sink               in_ch,
    output lsbc_pkg::lsbc_sample_t q_data,
    output logic                  q_valid,
    input  logic                  q_pop
);
    import lsbc_pkg::*;

    lsbc_sample_t        mem [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]     count_reg, count_next;
    logic                push, pop;
    lsbc_sample_t        entry;

    // bits above the sample width are dropped here
    always_comb
    begin
        entry.target        = sext_sample(in_ch.target);
        entry.first         = sext_sample(in_ch.first_model_out);
        entry.second        = sext_sample(in_ch.second_model_out);
        entry.rand_fraction = in_ch.rand_fraction;
        entry.last          = in_ch.last_sample;
    end

    assign in_ch.ready = (count_reg != (QPTR_W+1)'(QDEPTH));
    assign q_valid     = (count_reg != '0);
    assign q_data      = mem[rd_ptr_reg];
    assign push        = in_ch.valid && in_ch.ready;
    assign pop         = q_pop && q_valid;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end
endmodule

// ----- design/lsbc_div.sv -----
module lsbc_div (
    input  logic                   clk,
    input  logic                   rst_n,
    input  lsbc_pkg::lsbc_div_req_t req,
    output lsbc_pkg::lsbc_div_rsp_t rsp
);
    import lsbc_pkg::*;

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [DCNT_W-1:0]   cnt_reg, cnt_next;
    logic [DIVN_W-1:0]   numsh_reg, numsh_next;
    logic [WIDE_W-1:0]   den_reg, den_next;
    logic [WIDE_W-1:0]   rem_reg, rem_next;
    logic [Q_W-1:0]      q_reg, q_next;
    logic                ovf_reg, ovf_next;
    logic                neg_reg, neg_next;
    logic                dz_reg, dz_next;

    logic [WIDE_W-1:0]   num_mag, den_mag;
    logic [WIDE_W:0]     rem_sh;
    logic                ge;
    logic [Q_W-1:0]      lim, qs;

    assign num_mag = req.num[WIDE_W-1] ? WIDE_W'(-req.num) : WIDE_W'(req.num);
    assign den_mag = req.den[WIDE_W-1] ? WIDE_W'(-req.den) : WIDE_W'(req.den);
    assign rem_sh  = {rem_reg, numsh_reg[DIVN_W-1]};
    assign ge      = rem_sh >= {1'b0, den_reg};

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        numsh_next = numsh_reg;
        den_next   = den_reg;
        rem_next   = rem_reg;
        q_next     = q_reg;
        ovf_next   = ovf_reg;
        neg_next   = neg_reg;
        dz_next    = dz_reg;
        if (req.start)
        begin
            numsh_next = {num_mag, FRAC_W'(0)};
            den_next   = den_mag;
            rem_next   = '0;
            q_next     = '0;
            ovf_next   = 1'b0;
            neg_next   = req.num[WIDE_W-1] ^ req.den[WIDE_W-1];
            dz_next    = (req.den == '0);
            cnt_next   = DCNT_W'(DIVN_W);
            busy_next  = (req.den != '0);
            done_next  = (req.den == '0);
        end
        else if (busy_reg)
        begin
            rem_next   = ge ? WIDE_W'(rem_sh - {1'b0, den_reg}) : WIDE_W'(rem_sh);
            numsh_next = {numsh_reg[DIVN_W-2:0], 1'b0};
            q_next     = {q_reg[Q_W-2:0], ge};
            ovf_next   = ovf_reg | q_reg[Q_W-1];
            cnt_next   = cnt_reg - 1'b1;
            if (cnt_reg == DCNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // saturate toward the signed 32-bit bound of the result sign
    always_comb
    begin
        lim = neg_reg ? 33'h0_8000_0000 : 33'h0_7FFF_FFFF;
        qs  = (ovf_reg || (q_reg > lim)) ? lim : q_reg;
        rsp.done = done_reg;
        rsp.dz   = dz_reg;
        rsp.quot = neg_reg ? 32'(-qs) : 32'(qs);
    end

    always_ff @(posedge clk)
    begin
        numsh_reg <= numsh_next;
        den_reg   <= den_next;
        rem_reg   <= rem_next;
        q_reg     <= q_next;
        ovf_reg   <= ovf_next;
        neg_reg   <= neg_next;
        dz_reg    <= dz_next;
        cnt_reg   <= cnt_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end
endmodule

// ----- design/lsbc_back.sv -----
module lsbc_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  lsbc_pkg::lsbc_mode_t   blend_mode,
    input  logic [14:0]            weight_floor,
    input  lsbc_pkg::lsbc_sample_t q_data,
    input  logic                   q_valid,
    output logic                   q_pop,
    output lsbc_pkg::lsbc_div_req_t div_req,
    input  lsbc_pkg::lsbc_div_rsp_t div_rsp,
    lsbc_out_if.source             out_ch
);
    import lsbc_pkg::*;

    lsbc_state_t state_reg, state_next;

    // product stage
    logic               pv_reg, plast_reg;
    logic signed [31:0] pmm_reg, pmf_reg, pmt_reg, pff_reg, pft_reg;
    logic        [15:0] prand_reg;

    // sums
    logic signed [ACC_W-1:0] smm_reg, smf_reg, smt_reg, sff_reg, sft_reg;
    logic signed [ACC_W-1:0] smm_next, smf_next, smt_next, sff_next, sft_next;

    // solve
    logic [4:0]               step_reg;
    logic signed [WIDE_W-1:0] det_reg, nm_reg, nf_reg;
    logic signed [WIDE_W-1:0] det_next, nm_next, nf_next;
    logic [ACC_W-1:0]         pp_reg;
    logic [1:0]               pp_sh_reg;
    logic                     pp_neg_reg, pp_v_reg;
    lsbc_tgt_t                pp_tgt_reg;
    logic signed [31:0]       pm_reg, pf_reg;
    logic                     ok_reg;

    logic               out_valid_reg;
    logic signed [31:0] w1_reg, w2_reg;
    logic               wv_reg;

    // control
    logic acc_en, out_load, mul_issue;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_ACC:
            begin
                if (pv_reg && plast_reg)
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                case (blend_mode)
                    MODE_SINGLE: state_next = ST_DGO_M;
                    MODE_PAIR:   state_next = ST_MUL;
                    default:     state_next = ST_FIN;
                endcase
            end
            ST_MUL:
            begin
                if (step_reg == 5'(MUL_STEPS))
                begin
                    state_next = ST_DGO_M;
                end
            end
            ST_DGO_M: state_next = ST_DW_M;
            ST_DW_M:
            begin
                if (div_rsp.done)
                begin
                    state_next = (blend_mode == MODE_PAIR) ? ST_DGO_F : ST_FIN;
                end
            end
            ST_DGO_F: state_next = ST_DW_F;
            ST_DW_F:
            begin
                if (div_rsp.done)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    state_next = ST_ACC;
                end
            end
            default: state_next = ST_ACC;
        endcase
    end

    always_comb
    begin
        q_pop         = (state_reg == ST_ACC) && q_valid && !(pv_reg && plast_reg);
        acc_en        = (state_reg == ST_ACC) && pv_reg;
        out_load      = (state_reg == ST_FIN) && (!out_valid_reg || out_ch.ready);
        mul_issue     = (state_reg == ST_MUL) && (step_reg < 5'(MUL_STEPS));
        div_req.start = (state_reg == ST_DGO_M) || (state_reg == ST_DGO_F);
        div_req.num   = (state_reg == ST_DGO_F) ? nf_reg : nm_reg;
        div_req.den   = det_reg;
    end

    // accumulation
    always_comb
    begin
        smm_next = smm_reg;
        smf_next = smf_reg;
        smt_next = smt_reg;
        sff_next = sff_reg;
        sft_next = sft_reg;
        if (acc_en)
        begin
            smm_next = smm_reg + ACC_W'(pmm_reg);
            smf_next = smf_reg + ACC_W'(pmf_reg);
            smt_next = smt_reg + ACC_W'(pmt_reg);
            sff_next = sff_reg + ACC_W'(pff_reg);
            sft_next = sft_reg + ACC_W'(pft_reg);
        end
        if (out_load)
        begin
            smm_next = '0;
            smf_next = '0;
            smt_next = '0;
            sff_next = '0;
            sft_next = '0;
        end
    end

    // shared 24x24 partial product sequencer for the cramer terms
    logic signed [ACC_W-1:0] a_op, b_op;
    logic                    op_sub;
    lsbc_tgt_t               op_tgt;
    logic [ACC_W-1:0]        a_mag, b_mag;
    logic [HALF_W-1:0]       a_part, b_part;
    logic [WIDE_W-1:0]       ext, ext_sh;
    logic signed [WIDE_W-1:0] term;

    always_comb
    begin
        a_op   = smm_reg;
        b_op   = sff_reg;
        op_sub = 1'b0;
        op_tgt = TGT_DET;
        case (step_reg[4:2])
            3'd0: begin a_op = smm_reg; b_op = sff_reg; op_sub = 1'b0; op_tgt = TGT_DET; end
            3'd1: begin a_op = smf_reg; b_op = smf_reg; op_sub = 1'b1; op_tgt = TGT_DET; end
            3'd2: begin a_op = smt_reg; b_op = sff_reg; op_sub = 1'b0; op_tgt = TGT_NM;  end
            3'd3: begin a_op = sft_reg; b_op = smf_reg; op_sub = 1'b1; op_tgt = TGT_NM;  end
            3'd4: begin a_op = sft_reg; b_op = smm_reg; op_sub = 1'b0; op_tgt = TGT_NF;  end
            3'd5: begin a_op = smt_reg; b_op = smf_reg; op_sub = 1'b1; op_tgt = TGT_NF;  end
            default: begin a_op = '0; b_op = '0; op_sub = 1'b0; op_tgt = TGT_DET; end
        endcase
        a_mag  = a_op[ACC_W-1] ? ACC_W'(-a_op) : ACC_W'(a_op);
        b_mag  = b_op[ACC_W-1] ? ACC_W'(-b_op) : ACC_W'(b_op);
        a_part = step_reg[1] ? a_mag[ACC_W-1:HALF_W] : a_mag[HALF_W-1:0];
        b_part = step_reg[0] ? b_mag[ACC_W-1:HALF_W] : b_mag[HALF_W-1:0];
    end

    always_comb
    begin
        ext = {(WIDE_W-ACC_W)'(0), pp_reg};
        case (pp_sh_reg)
            2'd0:    ext_sh = ext;
            2'd1:    ext_sh = ext << HALF_W;
            default: ext_sh = ext << (2 * HALF_W);
        endcase
        term = pp_neg_reg ? -signed'(ext_sh) : signed'(ext_sh);
    end

    always_comb
    begin
        det_next = det_reg;
        nm_next  = nm_reg;
        nf_next  = nf_reg;
        if (state_reg == ST_PREP)
        begin
            if (blend_mode == MODE_SINGLE)
            begin
                nm_next  = WIDE_W'(smt_reg) - WIDE_W'(sft_reg) - WIDE_W'(smf_reg)
                         + WIDE_W'(sff_reg);
                det_next = WIDE_W'(smm_reg) - (WIDE_W'(smf_reg) <<< 1) + WIDE_W'(sff_reg);
            end
            else
            begin
                det_next = '0;
                nm_next  = '0;
                nf_next  = '0;
            end
        end
        else if (pp_v_reg)
        begin
            case (pp_tgt_reg)
                TGT_DET: det_next = det_reg + term;
                TGT_NM:  nm_next  = nm_reg + term;
                default: nf_next  = nf_reg + term;
            endcase
        end
    end

    // final weights and limit test
    logic [16:0]        span;
    logic [32:0]        rprod;
    logic signed [31:0] fin_pm, fin_pf;
    logic               fin_ok, fin_good;
    logic signed [33:0] one_minus;
    logic signed [32:0] pm33, pf33;
    logic [32:0]        am, af;

    always_comb
    begin
        span      = ONE_Q16 - {1'b0, weight_floor, 1'b0};
        rprod     = 33'(prand_reg) * 33'(span);
        one_minus = signed'(34'(ONE_Q16)) - 34'(pm_reg);
        fin_pm    = pm_reg;
        fin_pf    = pf_reg;
        fin_ok    = ok_reg;
        case (blend_mode)
            MODE_SINGLE:
            begin
                if (one_minus > 34'sh0_7FFF_FFFF)
                begin
                    fin_pf = 32'sh7FFF_FFFF;
                end
                else if (one_minus < -34'sh0_8000_0000)
                begin
                    fin_pf = 32'sh8000_0000;
                end
                else
                begin
                    fin_pf = 32'(one_minus);
                end
            end
            MODE_PAIR:
            begin
                fin_pf = pf_reg;
            end
            MODE_HALF:
            begin
                fin_pm = HALF_Q16;
                fin_pf = HALF_Q16;
                fin_ok = 1'b1;
            end
            default:
            begin
                fin_pm = 32'(weight_floor) + 32'(rprod[32:16]);
                fin_pf = 32'(ONE_Q16) - fin_pm;
                fin_ok = 1'b1;
            end
        endcase
        pm33     = 33'(fin_pm);
        pf33     = 33'(fin_pf);
        am       = pm33[32] ? 33'(-pm33) : 33'(pm33);
        af       = pf33[32] ? 33'(-pf33) : 33'(pf33);
        fin_good = fin_ok && !(am < 33'(weight_floor)) && !(af < 33'(weight_floor));
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.weight_first  = w1_reg;
    assign out_ch.weight_second = w2_reg;
    assign out_ch.weights_valid = wv_reg;

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            pmm_reg   <= 32'(q_data.first) * 32'(q_data.first);
            pmf_reg   <= 32'(q_data.first) * 32'(q_data.second);
            pmt_reg   <= 32'(q_data.first) * 32'(q_data.target);
            pff_reg   <= 32'(q_data.second) * 32'(q_data.second);
            pft_reg   <= 32'(q_data.second) * 32'(q_data.target);
            prand_reg <= q_data.rand_fraction;
            plast_reg <= q_data.last;
        end
        pp_reg     <= ACC_W'(a_part) * ACC_W'(b_part);
        pp_sh_reg  <= {1'b0, step_reg[1]} + {1'b0, step_reg[0]};
        pp_neg_reg <= a_op[ACC_W-1] ^ b_op[ACC_W-1] ^ op_sub;
        pp_tgt_reg <= op_tgt;
        det_reg    <= det_next;
        nm_reg     <= nm_next;
        nf_reg     <= nf_next;
        if ((state_reg == ST_DW_M) && div_rsp.done)
        begin
            pm_reg <= div_rsp.quot;
        end
        if ((state_reg == ST_DW_F) && div_rsp.done)
        begin
            pf_reg <= div_rsp.quot;
        end
        if (out_load)
        begin
            w1_reg <= fin_good ? fin_pm : '0;
            w2_reg <= fin_good ? fin_pf : '0;
            wv_reg <= fin_good;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_ACC;
            pv_reg        <= 1'b0;
            pp_v_reg      <= 1'b0;
            step_reg      <= '0;
            ok_reg        <= 1'b1;
            out_valid_reg <= 1'b0;
            smm_reg       <= '0;
            smf_reg       <= '0;
            smt_reg       <= '0;
            sff_reg       <= '0;
            sft_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pv_reg    <= q_pop;
            pp_v_reg  <= mul_issue;
            smm_reg   <= smm_next;
            smf_reg   <= smf_next;
            smt_reg   <= smt_next;
            sff_reg   <= sff_next;
            sft_reg   <= sft_next;
            if (state_reg == ST_PREP)
            begin
                step_reg <= '0;
                ok_reg   <= 1'b1;
            end
            else
            begin
                if (mul_issue)
                begin
                    step_reg <= step_reg + 1'b1;
                end
                if (((state_reg == ST_DW_M) || (state_reg == ST_DW_F)) &&
                    div_rsp.done && div_rsp.dz)
                begin
                    ok_reg <= 1'b0;
                end
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end
endmodule

// ----- design/least_squares_blend_coefficients.sv -----
// channel   dir  payload                                             transfer
// in_ch     in   target, first/second_model_out, rand_fraction, last  valid & ready
// out_ch    out  weight_first, weight_second, weights_valid           valid & ready
// apb       in   blend_mode @ 0x0, weight floor @ 0x4                 psel & penable & pwrite
//
// samples go one per cycle into a four-entry queue while in_ch.ready is high; the back end
// drains it one per cycle while accumulating; a solve follows each last sample: modes 2/3
// need no divide, mode 0 one 114-step divide, mode 1 24 partial products, then two divides
// during a solve the queue fills and then in_ch.ready drops; one result may wait in out_ch
// rst_n clears queue, sums, state and config (blend_mode 0, weight floor 66) at once
module least_squares_blend_coefficients (
    input  logic        clk,
    input  logic        rst_n,
    lsbc_in_if.sink     in_ch,
    lsbc_out_if.source  out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import lsbc_pkg::*;

    lsbc_mode_t    mode_reg;
    logic [14:0]   limit_reg;
    logic          cfg_wr;

    lsbc_sample_t  q_data;
    logic          q_valid;
    logic          q_pop;
    lsbc_div_req_t div_req;
    lsbc_div_rsp_t div_rsp;

    // register index is the word address
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == REG_WEIGHT_FLOOR) ? {17'b0, limit_reg} : {30'b0, mode_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_SINGLE;
            limit_reg <= 15'd66;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == REG_BLEND_MODE)
            begin
                mode_reg <= lsbc_mode_t'(pwdata[1:0]);
            end
            else
            begin
                limit_reg <= pwdata[14:0];
            end
        end
    end

    // front: accept and queue samples
    lsbc_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .q_data  (q_data),
        .q_valid (q_valid),
        .q_pop   (q_pop)
    );

    // back: accumulate, solve, hold the result
    lsbc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .blend_mode   (mode_reg),
        .weight_floor (limit_reg),
        .q_data       (q_data),
        .q_valid      (q_valid),
        .q_pop        (q_pop),
        .div_req      (div_req),
        .div_rsp      (div_rsp),
        .out_ch       (out_ch)
    );

    // one quotient bit per cycle
    lsbc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );
endmodule

// ----- design/lsbc_checker.sv -----
`include "least_squares_blend_coefficients_defines.svh"

module lsbc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] weight_first,
    input logic [31:0] weight_second,
    input logic        weights_valid,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [2:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata,
    input logic        pready
);
    `LSBC_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
    `LSBC_ASSERT_IMP(a_invalid_zero, out_valid && !weights_valid,
        (weight_first == 32'd0) && (weight_second == 32'd0), "invalid result carries weights")
    `LSBC_ASSERT_IMP(a_pready, 1'b1, pready, "pready low")
    `LSBC_ASSERT_NXT(a_mode_rb, psel && penable && pwrite && !paddr[2],
        !(psel && !pwrite && !paddr[2]) || (prdata[1:0] == $past(pwdata[1:0])),
        "mode readback mismatch")
endmodule

bind least_squares_blend_coefficients lsbc_checker u_lsbc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .weight_first  (out_ch.weight_first),
    .weight_second (out_ch.weight_second),
    .weights_valid (out_ch.weights_valid),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
);

// ----- bench/tb_least_squares_blend_coefficients.sv -----
module tb_least_squares_blend_coefficients;
    timeunit 1ns;
    timeprecision 1ps;
    import lsbc_pkg::*;

    // one expected blend result
    typedef struct {
        logic signed [31:0] w_first;
        logic signed [31:0] w_second;
        logic               ok;
    } blend_t;

    // running sums plus the register copy; predicts one result per finished set
    class blend_scoreboard;
        logic signed [47:0] s_mm, s_mf, s_mt, s_ff, s_ft;
        lsbc_mode_t         mode;
        logic [14:0]        limit;
        blend_t             pending[$];
        int                 mismatches;

        function new();
            s_mm = 0; s_mf = 0; s_mt = 0; s_ff = 0; s_ft = 0;
            mode = MODE_SINGLE;
            limit = 15'd66;
            mismatches = 0;
        endfunction

        // (num << 16) / den, truncate toward zero, saturate; returns 0 on zero den
        function automatic bit quotient(logic signed [127:0] num, logic signed [127:0] den,
                                        output logic signed [63:0] q);
            logic signed [127:0] r;
            q = 0;
            if (den == 0)
                return 0;
            r = (num <<< 16) / den;
            if (r > 128'sd2147483647)
                q = 64'sd2147483647;
            else if (r < -128'sd2147483648)
                q = -64'sd2147483648;
            else
                q = 64'(r);
            return 1;
        endfunction

        function automatic logic signed [63:0] sat(logic signed [63:0] v);
            if (v > 64'sd2147483647)
                return 64'sd2147483647;
            if (v < -64'sd2147483648)
                return -64'sd2147483648;
            return v;
        endfunction

        function void note_sample(logic signed [15:0] t, logic signed [15:0] m,
                                  logic signed [15:0] f, logic [15:0] rf, logic last);
            logic signed [63:0]  pm, pf, am, af, lim;
            logic signed [127:0] smm, smf, smt, sff, sft, det, nm, nf;
            bit                  ok;
            blend_t              b;
            s_mm += 48'(32'(m) * 32'(m));
            s_mf += 48'(32'(m) * 32'(f));
            s_mt += 48'(32'(m) * 32'(t));
            s_ff += 48'(32'(f) * 32'(f));
            s_ft += 48'(32'(f) * 32'(t));
            if (!last)
                return;
            smm = s_mm; smf = s_mf; smt = s_mt; sff = s_ff; sft = s_ft;
            lim = {49'd0, limit};
            pm = 0; pf = 0; ok = 1;
            case (mode)
                MODE_SINGLE:
                begin
                    ok = quotient(smt - sft - smf + sff, smm - 2 * smf + sff, pm);
                    pf = sat(64'sd65536 - pm);
                end
                MODE_PAIR:
                begin
                    det = smm * sff - smf * smf;
                    nm = smt * sff - sft * smf;
                    nf = sft * smm - smt * smf;
                    ok = quotient(nm, det, pm);
                    if (ok)
                        ok = quotient(nf, det, pf);
                end
                MODE_HALF:
                begin
                    pm = 32768;
                    pf = 32768;
                end
                default:
                begin
                    pm = lim + ((64'(rf) * (64'sd65536 - 2 * lim)) >>> 16);
                    pf = 64'sd65536 - pm;
                end
            endcase
            if (ok)
            begin
                am = pm < 0 ? -pm : pm;
                af = pf < 0 ? -pf : pf;
                if (am < lim || af < lim)
                    ok = 0;
            end
            if (!ok)
            begin
                pm = 0;
                pf = 0;
            end
            b.w_first = pm[31:0];
            b.w_second = pf[31:0];
            b.ok = ok;
            pending.push_back(b);
            s_mm = 0; s_mf = 0; s_mt = 0; s_ff = 0; s_ft = 0;
        endfunction

        function void check_result(logic signed [31:0] wf, logic signed [31:0] ws, logic v);
            blend_t b;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h %h %b", wf, ws, v);
                return;
            end
            b = pending.pop_front();
            if (b.w_first !== wf || b.w_second !== ws || b.ok !== v)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result mismatch: exp %h %h %b got %h %h %b",
                             b.w_first, b.w_second, b.ok, wf, ws, v);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        psel, penable, pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata, prdata;
    logic        pready;

    lsbc_in_if  in_ch();
    lsbc_out_if out_ch();

    least_squares_blend_coefficients uut (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    blend_scoreboard sb;
    bit              stim_done;
    int              hold_cycles;  // long receiver hold-off, counted in the sink process

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // a long fixed ceiling; mode 1 sets take the longest solve
    initial
    begin
        #20ms;
        $display("CHECK FAILED");
        $finish;
    end

    // gap length: mostly short, occasionally long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // setup cycle then access cycle; register written when penable is high
    task automatic reg_write(input logic idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_BLEND_MODE)
            sb.mode = lsbc_mode_t'(val[1:0]);
        else
            sb.limit = val[14:0];
    endtask

    // one transfer on the input channel; valid left high until the next gap or end_stream
    task automatic send_sample(input logic [15:0] t, input logic [15:0] m,
                               input logic [15:0] f, input logic [15:0] rf,
                               input logic last, input bit allow_gap);
        int g;
        g = allow_gap ? gap_len() : 0;
        if (g > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_ch.valid            <= 1'b1;
        in_ch.target           <= t;
        in_ch.first_model_out  <= m;
        in_ch.second_model_out <= f;
        in_ch.rand_fraction    <= rf;
        in_ch.last_sample      <= last;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        sb.note_sample(t, m, f, rf, last);
    endtask

    task automatic end_stream();
        in_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    // wait for all pending results, then the longest solve before touching registers
    task automatic drain();
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    // random sample value; mostly moderate, sometimes full range
    function automatic logic [15:0] rnd_val();
        if ($urandom_range(0, 3) == 0)
            return 16'($urandom);
        return 16'($signed($urandom_range(0, 2047)) - 1024);
    endfunction

    // random set of 1..n samples
    task automatic random_set(input int n, inout int count);
        int k;
        k = $urandom_range(1, n);
        for (int i = 0; i < k; i++)
        begin
            send_sample(rnd_val(), rnd_val(), rnd_val(), 16'($urandom),
                        i == k - 1, 1);
            count++;
        end
    endtask

    // result side: random stalls, one long hold-off
    initial
    begin
        int g;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_cycles > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (hold_cycles) @(posedge clk);
                hold_cycles = 0;
            end
            g = gap_len();
            if (g > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (g) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge clk);
            if (out_ch.valid && out_ch.ready)
                sb.check_result(out_ch.weight_first, out_ch.weight_second,
                                out_ch.weights_valid);
        end
    end

    initial
    begin
        int cnt;
        sb = new();
        rst_n = 1'b0;
        psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
        in_ch.valid = 0; in_ch.target = 0; in_ch.first_model_out = 0;
        in_ch.second_model_out = 0; in_ch.rand_fraction = 0; in_ch.last_sample = 0;
        stim_done = 0;
        hold_cycles = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset mode, extremes and a zero denominator
        send_sample(16'h7FFF, 16'h8000, 16'h7FFF, 16'h0000, 1'b0, 0);
        send_sample(16'h8000, 16'h8000, 16'h8000, 16'hFFFF, 1'b1, 0);
        send_sample(16'h0100, 16'h0100, 16'h0100, 16'h0000, 1'b1, 0); // m == f, den zero
        send_sample(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, 0);
        send_sample(16'h0300, 16'h0100, 16'h0000, 16'h0000, 1'b1, 0); // first weight above one
        end_stream();
        drain();

        reg_write(REG_BLEND_MODE, 32'(MODE_PAIR));
        reg_write(REG_WEIGHT_FLOOR, 32'h0000_0000);
        send_sample(16'h0100, 16'h0100, 16'h0000, 16'h0000, 1'b0, 0);
        send_sample(16'h0200, 16'h0000, 16'h0100, 16'h0000, 1'b1, 0);
        send_sample(16'h0100, 16'h0100, 16'h0200, 16'h0000, 1'b1, 0); // singular, det zero
        send_sample(16'h7FFF, 16'h7FFF, 16'h8000, 16'h0000, 1'b0, 0);
        send_sample(16'h8000, 16'h0001, 16'h7FFF, 16'h0000, 1'b1, 0);
        end_stream();
        drain();

        reg_write(REG_BLEND_MODE, 32'(MODE_HALF));
        reg_write(REG_WEIGHT_FLOOR, 32'hFFFF_FFFF);  // max floor; half still just passes
        send_sample(16'h1234, 16'h5678, 16'h9ABC, 16'h0000, 1'b1, 0);
        end_stream();
        drain();
        reg_write(REG_BLEND_MODE, 32'(MODE_RAND));
        send_sample(16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 1'b1, 0);
        end_stream();
        drain();
        reg_write(REG_WEIGHT_FLOOR, 32'd66);
        send_sample(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, 0);
        send_sample(16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 1'b1, 0);
        send_sample(16'h0000, 16'h0000, 16'h0000, 16'h8000, 1'b1, 0);
        end_stream();
        drain();

        // random phases across modes and limits; first phase adds a long receiver hold-off
        cnt = 0;
        for (int ph = 0; ph < 12; ph++)
        begin
            reg_write(REG_BLEND_MODE, 32'(ph % 4));
            case (ph % 3)
                0: reg_write(REG_WEIGHT_FLOOR, 32'($urandom_range(0, 300)));
                1: reg_write(REG_WEIGHT_FLOOR, 32'(16'($urandom)));
                default: reg_write(REG_WEIGHT_FLOOR, 32'd0);
            endcase
            if (ph == 0)
                hold_cycles = 400;
            for (int i = 0; i < 150; i = i)
            begin
                random_set(ph % 4 == 1 ? 12 : 6, i);
            end
            cnt += 150;
            end_stream();
            drain();
        end

        stim_done = 1;
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule

// ----- sim.f -----
+incdir+design
design/lsbc_pkg.sv
design/lsbc_in_if.sv
design/lsbc_out_if.sv
design/lsbc_front.sv
design/lsbc_div.sv
design/lsbc_back.sv
design/least_squares_blend_coefficients.sv
design/lsbc_checker.sv
bench/tb_least_squares_blend_coefficients.sv
